[hdl/tgf_pkg.sv]
package tgf_pkg;

   localparam int TIME_W   = 32;
   localparam int STEP_W   = 8;
   localparam int SUM_W    = TIME_W + 1;
   localparam int CSR_IDX_W = 2;

   // fillers per item are capped; the rest of a gap is dropped and flagged
   localparam int MAX_FILL = 63;
   localparam int FILL_W   = $clog2(MAX_FILL + 1);
   // the scan count must hold the cap plus one extra filler
   localparam int CNT_W    = $clog2(MAX_FILL + 3);
   localparam logic [CNT_W-1:0] SCAN_CAP = CNT_W'(MAX_FILL + 1);

   localparam logic [STEP_W-1:0] DRIFT_STEP = STEP_W'(2);
   localparam logic [STEP_W-1:0] UNIT_STEP  = STEP_W'(1);

   localparam logic [CSR_IDX_W-1:0] CSR_START_TIME = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_END_TIME   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP  = CSR_IDX_W'(2);

   typedef struct packed {
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
      logic [STEP_W-1:0] time_step;
   } cfg_type;

   // operands of the shared adder and comparator
   typedef struct packed {
      logic [SUM_W-1:0]  add_a;
      logic [STEP_W-1:0] add_b;
      logic [SUM_W-1:0]  cmp_a;
      logic [SUM_W-1:0]  cmp_b;
   } alu_req_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             lt;
   } alu_rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] out_time;
      logic [TIME_W-1:0] out_value;
      logic              is_filler;
      logic              drift_fixed;
      logic              truncated;
      logic              last;
   } rsp_type;

endpackage

[hdl/tgf_req_if.sv]
interface tgf_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [31:0] in_time;
   logic [31:0] in_value;

   modport source (output valid, output mode, output in_time, output in_value, input ready);
   modport sink   (input valid, input mode, input in_time, input in_value, output ready);
endinterface

[hdl/tgf_rsp_if.sv]
interface tgf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_time;
   logic [31:0] out_value;
   logic        is_filler;
   logic        drift_fixed;
   logic        truncated;
   logic        last;

   modport source (output valid, output out_time, output out_value, output is_filler,
                   output drift_fixed, output truncated, output last, input ready);
   modport sink   (input valid, input out_time, input out_value, input is_filler,
                   input drift_fixed, input truncated, input last, output ready);
endinterface

[hdl/tgf_csr.sv]
module tgf_csr
   import tgf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_TIME: cfg_in.start_time = csr_wdata;
            CSR_END_TIME:   cfg_in.end_time   = csr_wdata;
            CSR_TIME_STEP:  cfg_in.time_step  = csr_wdata[STEP_W-1:0];
            default:        cfg_in = cfg_ff;   // drop writes to unknown registers
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_time <= '0;
         cfg_ff.end_time   <= '0;
         cfg_ff.time_step  <= UNIT_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/tgf_alu.sv]
module tgf_alu
   import tgf_pkg::*;
(
   input  alu_req_type op,
   output alu_rsp_type res
);

   assign res.sum = op.add_a + SUM_W'(op.add_b);
   assign res.lt  = op.cmp_a < op.cmp_b;

endmodule

[hdl/tgf_seq.sv]
module tgf_seq
   import tgf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   tgf_req_if.sink     req_chan,
   tgf_rsp_if.source   rsp_chan,
   output alu_req_type alu_op,
   input  alu_rsp_type alu_res
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic              mode_ff, mode_in;
   logic [TIME_W-1:0] t_ff, t_in;
   logic [TIME_W-1:0] value_ff, value_in;
   logic [TIME_W-1:0] n_ff, n_in;
   logic [STEP_W-1:0] s_ff, s_in;
   logic [SUM_W-1:0]  probe_ff, probe_in;
   logic [SUM_W-1:0]  bound_ff, bound_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [FILL_W-1:0] rem_ff, rem_in;
   logic              trunc_ff, trunc_in;
   logic              drift_ff, drift_in;
   logic [TIME_W-1:0] next_ff, next_in;
   logic              started_ff, started_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic              out_free;
   logic [STEP_W-1:0] s_sel;
   logic [TIME_W-1:0] n_sel;
   logic              drift_w;
   logic              extra_w;
   logic [CNT_W-1:0]  total_w;
   logic              trunc_w;
   logic [FILL_W-1:0] emit_w;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign s_sel = (cfg.time_step == '0) ? UNIT_STEP : cfg.time_step;
   assign n_sel = started_ff ? next_ff : cfg.start_time;

   // with step 2 a sample an odd distance past the expected slot lands one
   // second past a grid slot and is pulled back
   assign drift_w = !mode_ff && (s_ff == DRIFT_STEP) && (t_ff > n_ff) && (t_ff[0] != n_ff[0]);
   assign extra_w = !mode_ff && (t_ff != n_ff) && !drift_w;
   assign total_w = cnt_ff + CNT_W'(extra_w);
   assign trunc_w = total_w > CNT_W'(MAX_FILL);
   assign emit_w  = trunc_w ? FILL_W'(MAX_FILL) : total_w[FILL_W-1:0];

   // shared adder and comparator operands
   always_comb begin
      alu_op.cmp_a = probe_ff;
      alu_op.cmp_b = bound_ff;
      unique case (state_ff)
         ST_IDLE: begin
            alu_op.add_a = SUM_W'(req_chan.mode ? cfg.end_time : n_sel);
            alu_op.add_b = s_sel;
         end
         ST_SCAN: begin
            alu_op.add_a = probe_ff;
            alu_op.add_b = s_ff;
         end
         ST_EMIT: begin
            if (rem_ff != '0) begin
               alu_op.add_a = probe_ff;
               alu_op.add_b = s_ff;
            end else begin
               alu_op.add_a = SUM_W'(t_ff);
               alu_op.add_b = drift_ff ? UNIT_STEP : s_ff;
            end
         end
         default: begin
            alu_op.add_a = probe_ff;
            alu_op.add_b = s_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      t_in         = t_ff;
      value_in     = value_ff;
      n_in         = n_ff;
      s_in         = s_ff;
      probe_in     = probe_ff;
      bound_in     = bound_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      trunc_in     = trunc_ff;
      drift_in     = drift_ff;
      next_in      = next_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in  = req_chan.mode;
               t_in     = req_chan.in_time;
               value_in = req_chan.in_value;
               n_in     = n_sel;
               s_in     = s_sel;
               cnt_in   = '0;
               if (req_chan.mode) begin
                  // count slots from n below end_time + step
                  probe_in = SUM_W'(n_sel);
                  bound_in = alu_res.sum;
               end else begin
                  // count slots after n that lie below the sample time
                  probe_in = alu_res.sum;
                  bound_in = SUM_W'(req_chan.in_time);
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (alu_res.lt && (cnt_ff != SCAN_CAP)) begin
               cnt_in   = cnt_ff + CNT_W'(1);
               probe_in = alu_res.sum;
            end else begin
               drift_in = drift_w;
               trunc_in = trunc_w;
               rem_in   = emit_w;
               probe_in = SUM_W'(n_ff);
               if (mode_ff && (emit_w == '0)) begin
                  started_in = 1'b0;
                  next_in    = '0;
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (rem_ff != '0) begin
                  rsp_in.out_time    = probe_ff[TIME_W-1:0];
                  rsp_in.out_value   = '0;
                  rsp_in.is_filler   = 1'b1;
                  rsp_in.drift_fixed = 1'b0;
                  rsp_in.truncated   = trunc_ff;
                  rsp_in.last        = mode_ff && (rem_ff == FILL_W'(1));
                  probe_in = alu_res.sum;
                  rem_in   = rem_ff - FILL_W'(1);
                  if (mode_ff && (rem_ff == FILL_W'(1))) begin
                     started_in = 1'b0;
                     next_in    = '0;
                     state_in   = ST_IDLE;
                  end
               end else begin
                  rsp_in.out_time    = t_ff - TIME_W'(drift_ff);
                  rsp_in.out_value   = value_ff;
                  rsp_in.is_filler   = 1'b0;
                  rsp_in.drift_fixed = drift_ff;
                  rsp_in.truncated   = trunc_ff;
                  rsp_in.last        = 1'b1;
                  next_in    = alu_res.sum[TIME_W-1:0];
                  started_in = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         next_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         rem_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         next_ff      <= next_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      t_ff     <= t_in;
      value_ff <= value_in;
      n_ff     <= n_in;
      s_ff     <= s_in;
      probe_ff <= probe_in;
      bound_ff <= bound_in;
      trunc_ff <= trunc_in;
      drift_ff <= drift_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_time    = rsp_ff.out_time;
   assign rsp_chan.out_value   = rsp_ff.out_value;
   assign rsp_chan.is_filler   = rsp_ff.is_filler;
   assign rsp_chan.drift_fixed = rsp_ff.drift_fixed;
   assign rsp_chan.truncated   = rsp_ff.truncated;
   assign rsp_chan.last        = rsp_ff.last;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= SCAN_CAP)
      else $error("scan count beyond cap");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN))
      else $error("accepted item did not start a scan");

   a_row_rearm: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && (rem_ff == '0) && out_free)
      |=> (started_ff && (state_ff == ST_IDLE) && rsp_valid_ff && rsp_chan.last))
      else $error("sample row did not close the item");

   a_drift_step: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && drift_ff) |-> ((s_ff == DRIFT_STEP) && !mode_ff))
      else $error("drift fix outside step-2 sample");

endmodule

[hdl/timestamp_gap_filler_core.sv]
// channel  | dir | handshake            | payload
// req_chan | in  | valid/ready          | mode, in_time, in_value
// rsp_chan | out | valid/ready          | out_time, out_value, is_filler, drift_fixed,
//          |     |                      | truncated, last
// csr      | in  | csr_we, no wait      | csr_index, csr_wdata
//
// An item is taken, then a shared adder/comparator walks the grid slots, one per
// cycle, to count the gap, then emits one result per cycle while rsp_chan is not
// stalled. req_chan.ready is low from acceptance until the last result is loaded,
// or until the scan ends when a finish has no filler to emit.
// A stalled rsp_chan holds the output register and pauses emission; reset clears state.
module timestamp_gap_filler_core
   import tgf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   tgf_req_if.sink              req_chan,
   tgf_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_wdata
);

   cfg_type     cfg;
   alu_req_type alu_op;
   alu_rsp_type alu_res;

   tgf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tgf_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   tgf_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .alu_op   (alu_op),
      .alu_res  (alu_res)
   );

endmodule

[tb/sv/timestamp_gap_filler_core_tb.sv]
module timestamp_gap_filler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tgf_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int SETTLE_CYCLES  = 150;
   localparam int RANDOM_PER_SEG = 44;
   localparam int NUM_SEGS       = 6;

   localparam bit MODE_SAMPLE = 1'b0;
   localparam bit MODE_FINISH = 1'b1;

   // index 3 is not decoded by the block
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(3);

   localparam logic [TIME_W-1:0] SEG_START [NUM_SEGS] =
      '{32'd100, 32'd0, 32'hFFFF_FF00, 32'd5000, 32'hFFFF_FFFF, 32'd1000};
   localparam logic [TIME_W-1:0] SEG_END [NUM_SEGS] =
      '{32'd180, 32'd0, 32'hFFFF_FFFF, 32'd5100, 32'd0, 32'd2000};
   localparam logic [STEP_W-1:0] SEG_STEP [NUM_SEGS] =
      '{8'd1, 8'd2, 8'd255, 8'd0, 8'd2, 8'd3};

   class gap_fill_scoreboard;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
      logic [TIME_W-1:0] next_time;
      logic [STEP_W-1:0] time_step;
      bit                started;
      rsp_type           expected_rows[$];
      int                errors;

      function new();
         start_time = '0;
         end_time   = '0;
         time_step  = UNIT_STEP;
         next_time  = '0;
         started    = 1'b0;
         errors     = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
         case (idx)
            CSR_START_TIME: start_time = data;
            CSR_END_TIME:   end_time = data;
            CSR_TIME_STEP:  time_step = data[STEP_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [TIME_W-1:0] slot_base();
         return started ? next_time : start_time;
      endfunction

      function logic [TIME_W-1:0] grid_step();
         return (time_step == '0) ? TIME_W'(UNIT_STEP) : TIME_W'(time_step);
      endfunction

      function int pending();
         return expected_rows.size();
      endfunction

      function void push_fillers(longint unsigned base, longint unsigned step,
                                 longint unsigned count, bit trunc, bit mark_last);
         rsp_type row;
         for (longint unsigned j = 0; j < count; j++) begin
            row.out_time    = TIME_W'(base + j * step);
            row.out_value   = '0;
            row.is_filler   = 1'b1;
            row.drift_fixed = 1'b0;
            row.truncated   = trunc;
            row.last        = mark_last && (j == count - 1);
            expected_rows.insert(expected_rows.size(), row);
         end
      endfunction

      function void note_input(bit mode, logic [TIME_W-1:0] t_in, logic [TIME_W-1:0] v_in);
         longint unsigned s, n, t, total, emit, loops, slot, lim;
         bit              trunc, drift;
         rsp_type         row;
         s     = grid_step();
         n     = slot_base();
         t     = t_in;
         total = 0;
         drift = 1'b0;
         if (mode == MODE_FINISH) begin
            lim = end_time;
            lim = lim + s;
            if (n < lim)
               total = (lim - n + s - 1) / s;
            trunc = total > MAX_FILL;
            emit  = trunc ? MAX_FILL : total;
            push_fillers(n, s, emit, trunc, 1'b1);
            started   = 1'b0;
            next_time = '0;
            return;
         end
         if (t == n) begin
            total = 0;
         end else if (s == DRIFT_STEP && t == n + 1) begin
            t     = n;
            drift = 1'b1;
         end else begin
            loops = 0;
            if (n + s < t)
               loops = (t - n - 1) / s;
            slot = n + loops * s;
            // one second past the last slot at step 2: pull back instead of filling
            if (s == DRIFT_STEP && t == slot + 1) begin
               t     = t - 1;
               drift = 1'b1;
               total = loops;
            end else begin
               total = loops + 1;
            end
         end
         trunc = total > MAX_FILL;
         emit  = trunc ? MAX_FILL : total;
         push_fillers(n, s, emit, trunc, 1'b0);
         row.out_time    = TIME_W'(t);
         row.out_value   = v_in;
         row.is_filler   = 1'b0;
         row.drift_fixed = drift;
         row.truncated   = trunc;
         row.last        = 1'b1;
         expected_rows.insert(expected_rows.size(), row);
         next_time = TIME_W'(t + s);
         started   = 1'b1;
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("%0t mismatch:%s", $time, msg);
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         string   bad;
         if (expected_rows.size() == 0) begin
            report_mismatch($sformatf(" unexpected result time %h value %h filler %b",
                                      got.out_time, got.out_value, got.is_filler));
            return;
         end
         want = expected_rows.pop_front();
         bad  = "";
         if (got.out_time !== want.out_time)       bad = {bad, " out_time"};
         if (got.out_value !== want.out_value)     bad = {bad, " out_value"};
         if (got.is_filler !== want.is_filler)     bad = {bad, " is_filler"};
         if (got.drift_fixed !== want.drift_fixed) bad = {bad, " drift_fixed"};
         if (got.truncated !== want.truncated)     bad = {bad, " truncated"};
         if (got.last !== want.last)               bad = {bad, " last"};
         if (bad != "")
            report_mismatch($sformatf("%s: got %h/%h %b%b%b%b, want %h/%h %b%b%b%b", bad,
               got.out_time, got.out_value, got.is_filler, got.drift_fixed,
               got.truncated, got.last, want.out_time, want.out_value, want.is_filler,
               want.drift_fixed, want.truncated, want.last));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TIME_W-1:0]    csr_wdata;

   tgf_req_if req_chan ();
   tgf_rsp_if rsp_chan ();

   timestamp_gap_filler_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   gap_fill_scoreboard sb;
   rsp_type            seen_row;
   int                 send_idle_pct = 29;
   int                 recv_idle_pct = 45;
   int                 cycle_count = 0;

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_row.out_time    = rsp_chan.out_time;
            seen_row.out_value   = rsp_chan.out_value;
            seen_row.is_filler   = rsp_chan.is_filler;
            seen_row.drift_fixed = rsp_chan.drift_fixed;
            seen_row.truncated   = rsp_chan.truncated;
            seen_row.last        = rsp_chan.last;
            sb.check_result(seen_row);
         end
         if (req_chan.valid && req_chan.ready)
            sb.note_input(req_chan.mode, req_chan.in_time, req_chan.in_value);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timestamp_gap_filler_core_tb: errors");
         $finish;
      end
   end

   // All driving tasks start and end just after a falling edge.
   task automatic send_item(input bit mode, input logic [TIME_W-1:0] t,
                            input logic [TIME_W-1:0] v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.mode     <= mode;
      req_chan.in_time  <= t;
      req_chan.in_value <= v;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // drain, then let the block settle idle
   task automatic quiesce();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic random_item();
      logic [TIME_W-1:0] n, s, t;
      int                pick;
      if ($urandom_range(0, 39) == 0)
         wait_drained();
      n    = sb.slot_base();
      s    = sb.grid_step();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         send_item(MODE_FINISH, $urandom, $urandom);
         return;
      end
      if (pick < 30)
         t = n;
      else if (pick < 45)
         t = n + 1;
      else if (pick < 80)
         t = n + $urandom_range(1, 6) * s
               + ($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(0, s - 1));
      else if (pick < 88)
         t = n - $urandom_range(1, 300);
      else if (pick < 93)
         t = n + $urandom_range(55, 80) * s;
      else
         t = $urandom;
      send_item(MODE_SAMPLE, t, $urandom);
   endtask

   initial begin
      req_chan.valid    = 1'b0;
      req_chan.mode     = MODE_SAMPLE;
      req_chan.in_time  = '0;
      req_chan.in_value = '0;
      rsp_chan.ready    = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_START_TIME;
      csr_wdata         = '0;
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_csr(CSR_START_TIME, 32'd100);
      write_csr(CSR_END_TIME, 32'd120);
      write_csr(CSR_TIME_STEP, 32'd2);
      write_csr(CSR_SPARE, 32'hDEAD_BEEF);

      // step 2 grid from 100: on grid, plain drift, on grid, gap ending in drift, gap, backward, truncated gap
      send_item(MODE_SAMPLE, 32'd100, 32'h0000_0000);
      send_item(MODE_SAMPLE, 32'd103, 32'hFFFF_FFFF);
      send_item(MODE_SAMPLE, 32'd104, 32'h1234_5678);
      send_item(MODE_SAMPLE, 32'd111, 32'hA5A5_5A5A);
      send_item(MODE_SAMPLE, 32'd120, 32'h5A5A_A5A5);
      send_item(MODE_SAMPLE, 32'd50, 32'h0000_0001);
      send_item(MODE_SAMPLE, 32'd0, 32'h8000_0000);
      send_item(MODE_SAMPLE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      // pad after a wrapped grid, then pad from a re-armed start
      send_item(MODE_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(MODE_FINISH, 32'd0, 32'd0);
      quiesce();
      write_csr(CSR_END_TIME, 32'd0);
      send_item(MODE_FINISH, 32'd7, 32'd9);
      quiesce();
      write_csr(CSR_TIME_STEP, 32'd1);
      write_csr(CSR_END_TIME, 32'hFFFF_FFFF);
      send_item(MODE_SAMPLE, 32'd100, 32'hCAFE_0001);
      send_item(MODE_SAMPLE, 32'd102, 32'hCAFE_0002);
      send_item(MODE_FINISH, 32'd0, 32'd0);

      for (int seg = 0; seg < NUM_SEGS; seg++) begin
         quiesce();
         if (seg < 2) begin
            send_idle_pct = 29;
            recv_idle_pct = 45;
         end else if (seg < 4) begin
            send_idle_pct = 45;
            recv_idle_pct = 29;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_csr(CSR_START_TIME, SEG_START[seg]);
         write_csr(CSR_END_TIME, SEG_END[seg]);
         write_csr(CSR_TIME_STEP, TIME_W'(SEG_STEP[seg]));
         // re-arm so the new start time takes effect
         send_item(MODE_FINISH, $urandom, $urandom);
         repeat (RANDOM_PER_SEG) random_item();
      end

      quiesce();
      if (sb.errors == 0)
         $display("timestamp_gap_filler_core_tb: clean");
      else
         $display("timestamp_gap_filler_core_tb: errors");
      $finish;
   end

endmodule
